### hdl/ddc_pkg.sv
// Shared types, constants and calendar tables for the date/day-count converter.
// No dependencies; used by the top level and by its port checker.
`default_nettype none

package ddc_pkg;

    // Conversion direction carried in the action field
    localparam logic ACT_TO_COUNT = 1'b0;
    localparam logic ACT_TO_DATE  = 1'b1;

    localparam logic [13:0] BASE_YEAR     = 14'd1900;
    localparam logic [13:0] LAST_YEAR     = 14'd9999;
    localparam logic [21:0] MAX_COUNT     = 22'd2958463;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
    localparam int          YEAR_DAYS     = 365;

    // Leap years in 1..1899, removed so that the count starts at 1900-01-01
    localparam logic [11:0] LEAPS_TO_BASE = 12'(1899 / 4 - 1899 / 100 + 1899 / 400);

    // 400-year era arithmetic, eras counted from 1600-03-01
    localparam int          ERA_DAYS      = 146097;
    localparam int          CENT_DAYS     = 36524;
    localparam logic [13:0] ERA_BASE_YEAR = 14'd1600;
    localparam int          ERA_YEARS     = 400;
    // Days from 1600-03-01 to 1900-01-01
    localparam logic [21:0] EPOCH_SHIFT   = 22'd109513;
    // Month index (March based) of January
    localparam logic [3:0]  MP_JAN        = 4'd10;

    typedef struct packed {
        logic        action;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [21:0] count_in;
    } ddc_in_t;

    typedef struct packed {
        logic [21:0] count_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        error;
    } ddc_out_t;

    // Length of a month in a common year; zero for codes that are no month
    function automatic logic [4:0] month_days(input logic [3:0] month);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   return 5'd30;
            4'd2:                                      return 5'd28;
            default:                                   return 5'd0;
        endcase
    endfunction

    // Days in a common year before the first of the month
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        case (month)
            4'd2:    return 9'd31;
            4'd3:    return 9'd59;
            4'd4:    return 9'd90;
            4'd5:    return 9'd120;
            4'd6:    return 9'd151;
            4'd7:    return 9'd181;
            4'd8:    return 9'd212;
            4'd9:    return 9'd243;
            4'd10:   return 9'd273;
            4'd11:   return 9'd304;
            4'd12:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

    // Day offset of a month inside a March-based year (0 = March, 11 = February)
    function automatic logic [8:0] march_offset(input logic [3:0] mp);
        case (mp)
            4'd1:    return 9'd31;
            4'd2:    return 9'd61;
            4'd3:    return 9'd92;
            4'd4:    return 9'd122;
            4'd5:    return 9'd153;
            4'd6:    return 9'd184;
            4'd7:    return 9'd214;
            4'd8:    return 9'd245;
            4'd9:    return 9'd275;
            4'd10:   return 9'd306;
            4'd11:   return 9'd337;
            default: return 9'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### hdl/date_day_count_converter.sv
// Gregorian date <-> day count (days since 1900-01-01) converter, seven-stage pipeline.
// Depends on ddc_pkg for the transfer structs, calendar constants and month tables.
//
//   channel | ports                        | payload         | direction
//   --------+------------------------------+-----------------+----------
//   input   | s_valid, s_ready, s_data     | ddc_in_t        | in
//   result  | m_valid, m_ready, m_data     | ddc_out_t       | out
//
// Every input transfer yields exactly one result transfer. One transfer is taken per
// cycle while the result side does not stall; the work is split over the seven
// register stages, each holding multipliers, adders or compares.
// Reset (aresetn low at a clock edge) empties all stages; payload registers keep junk.
// A stall on m_ready holds the result; upstream stages keep filling empty slots, so
// s_ready drops only once every stage holds a valid item.
`default_nettype none

module date_day_count_converter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ddc_pkg::ddc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ddc_pkg::ddc_out_t  m_data
);
    import ddc_pkg::*;

    localparam int NUM_STAGES = 7;

    // Reciprocal constants: floor(x * MUL / 2^SH) == floor(x / D) for every x in range
    localparam int          ERA_SH     = 40;   // 22-bit dividend, divisor below 2^18
    localparam logic [22:0] ERA_MUL    =
        23'(((64'd1 << ERA_SH) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));
    localparam int          Y100_SH    = 21;   // 14-bit dividend, divisor below 2^7
    localparam logic [14:0] Y100_MUL   = 15'(((64'd1 << Y100_SH) + 64'd99) / 64'd100);
    localparam int          Q1460_SH   = 29;   // 18-bit dividend, divisor below 2^11
    localparam logic [18:0] Q1460_MUL  =
        19'(((64'd1 << Q1460_SH) + 64'(4 * YEAR_DAYS) - 64'd1) / 64'(4 * YEAR_DAYS));
    localparam int          Q365_SH    = 27;   // 18-bit dividend, divisor below 2^9
    localparam logic [18:0] Q365_MUL   =
        19'(((64'd1 << Q365_SH) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));
    localparam int          YOE100_SH  = 16;   // 9-bit dividend, divisor below 2^7
    localparam logic [9:0]  YOE100_MUL = 10'(((64'd1 << YOE100_SH) + 64'd99) / 64'd100);

    // Stage 1: range flags, year/100 quotients, era of the shifted count
    typedef struct packed {
        logic        act;
        logic        err;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [7:0]  qy;     // year / 100
        logic [7:0]  qn;     // (year - 1) / 100
        logic [21:0] z;      // days since 1600-03-01
        logic [4:0]  era;
    } st1_t;

    // Stage 2: date validity, split day sum; day of era
    typedef struct packed {
        logic        act;
        logic        err;
        logic [21:0] ydays;
        logic [11:0] adj;
        logic [17:0] doe;
        logic [4:0]  era;
    } st2_t;

    // Stage 3: finished day count; four-year and century corrections
    typedef struct packed {
        logic        act;
        logic        err;
        logic [21:0] total;
        logic [17:0] doe;
        logic [6:0]  q1460;
        logic [1:0]  cent;
        logic [4:0]  era;
    } st3_t;

    // Stage 4: year of era
    typedef struct packed {
        logic        act;
        logic        err;
        logic [21:0] total;
        logic [17:0] doe;
        logic [8:0]  yoe;
        logic [4:0]  era;
    } st4_t;

    // Stage 5: day of March-based year, March-based calendar year
    typedef struct packed {
        logic        act;
        logic        err;
        logic [21:0] total;
        logic [8:0]  doy;
        logic [13:0] yr;
    } st5_t;

    // Stage 6: March-based month
    typedef struct packed {
        logic        act;
        logic        err;
        logic [21:0] total;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [13:0] yr;
    } st6_t;

    logic [NUM_STAGES:1] vld_reg, vld_next;
    logic [NUM_STAGES:1] adv;

    st1_t     st1_reg, st1_next;
    st2_t     st2_reg, st2_next;
    st3_t     st3_reg, st3_next;
    st4_t     st4_reg, st4_next;
    st5_t     st5_reg, st5_next;
    st6_t     st6_reg, st6_next;
    ddc_out_t out_reg, out_next;

    // Stage 1 datapath
    logic [21:0] z_s1;
    logic [44:0] era_prod_s1;
    logic [13:0] ym1_s1;
    logic [28:0] qy_prod_s1;
    logic [28:0] qn_prod_s1;

    // Stage 2 datapath
    logic        leap_s2;
    logic [4:0]  dim_s2;
    logic        fwd_err_s2;
    logic [13:0] n_s2;
    logic [13:0] yoff_s2;
    logic [22:0] era_days_s2;

    // Stage 3 to 5 datapath
    logic [36:0] q1460_prod_s3;
    logic [17:0] num_s4;
    logic [36:0] yoe_prod_s4;
    logic [18:0] c100_prod_s5;
    logic [17:0] yday_sum_s5;

    // ------------------------------------------------------------------
    // Flow control: a stage advances when it is empty or its successor
    // advances, so bubbles collapse during a stall on the result side.
    // ------------------------------------------------------------------
    always_comb begin
        adv[NUM_STAGES] = !vld_reg[NUM_STAGES] || m_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (adv[1]) begin
            vld_next[1] = s_valid;
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
                vld_next[k] = vld_reg[k - 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the count to the 1600-03-01 epoch and take its era;
    // take year / 100 and (year - 1) / 100 for the leap and leap-count terms.
    // ------------------------------------------------------------------
    always_comb begin
        z_s1        = s_data.count_in + EPOCH_SHIFT;
        era_prod_s1 = z_s1 * ERA_MUL;
        ym1_s1      = s_data.year_in - 14'd1;
        qy_prod_s1  = s_data.year_in * Y100_MUL;
        qn_prod_s1  = ym1_s1 * Y100_MUL;

        st1_next.act   = s_data.action;
        st1_next.err   = (s_data.action == ACT_TO_DATE) && (s_data.count_in > MAX_COUNT);
        st1_next.year  = s_data.year_in;
        st1_next.month = s_data.month_in;
        st1_next.day   = s_data.day_in;
        st1_next.qy    = qy_prod_s1[Y100_SH +: 8];
        st1_next.qn    = qn_prod_s1[Y100_SH +: 8];
        st1_next.z     = z_s1;
        st1_next.era   = era_prod_s1[ERA_SH +: 5];
    end

    // ------------------------------------------------------------------
    // Stage 2: check the date; form 365 * (year - 1900) and the small terms
    // (leap days, days before the month, day of month); strip the era.
    // ------------------------------------------------------------------
    always_comb begin
        // Divisible by 4, and either no century year or the century divisible by 4
        leap_s2 = (st1_reg.year[1:0] == 2'b00)
                  && ((st1_reg.qy == st1_reg.qn) || (st1_reg.qy[1:0] == 2'b00));
        dim_s2  = ((st1_reg.month == MONTH_FEB) && leap_s2) ? FEB_LEAP_DAYS
                                                            : month_days(st1_reg.month);
        fwd_err_s2 = (st1_reg.year < BASE_YEAR) || (st1_reg.year > LAST_YEAR)
                     || !(st1_reg.month inside {[4'd1:MONTH_DEC]})
                     || (st1_reg.day == 5'd0) || (st1_reg.day > dim_s2);

        n_s2        = st1_reg.year - 14'd1;
        yoff_s2     = st1_reg.year - BASE_YEAR;
        era_days_s2 = st1_reg.era * 18'(ERA_DAYS);

        st2_next.act   = st1_reg.act;
        st2_next.err   = (st1_reg.act == ACT_TO_DATE) ? st1_reg.err : fwd_err_s2;
        st2_next.ydays = 22'(yoff_s2) * 22'(YEAR_DAYS);
        st2_next.adj   = 12'(n_s2[13:2]) - 12'(st1_reg.qn) + 12'(st1_reg.qn[7:2])
                         + 12'(days_before_month(st1_reg.month))
                         + 12'(leap_s2 && (st1_reg.month > MONTH_FEB))
                         + 12'(st1_reg.day) - 12'd1 - LEAPS_TO_BASE;
        st2_next.doe   = 18'(st1_reg.z - era_days_s2[21:0]);
        st2_next.era   = st1_reg.era;
    end

    // ------------------------------------------------------------------
    // Stage 3: finish the day count; take doe / 1460 and the century
    // correction (doe / 36524 - doe / 146096, three compares).
    // ------------------------------------------------------------------
    always_comb begin
        q1460_prod_s3 = st2_reg.doe * Q1460_MUL;

        st3_next.act   = st2_reg.act;
        st3_next.err   = st2_reg.err;
        st3_next.total = st2_reg.ydays + 22'(st2_reg.adj);
        st3_next.doe   = st2_reg.doe;
        st3_next.q1460 = q1460_prod_s3[Q1460_SH +: 7];
        st3_next.cent  = 2'(st2_reg.doe >= 18'(CENT_DAYS))
                         + 2'(st2_reg.doe >= 18'(2 * CENT_DAYS))
                         + 2'(st2_reg.doe >= 18'(3 * CENT_DAYS));
        st3_next.era   = st2_reg.era;
    end

    // ------------------------------------------------------------------
    // Stage 4: year of era = (doe - doe/1460 + century correction) / 365.
    // ------------------------------------------------------------------
    always_comb begin
        num_s4      = st3_reg.doe - 18'(st3_reg.q1460) + 18'(st3_reg.cent);
        yoe_prod_s4 = num_s4 * Q365_MUL;

        st4_next.act   = st3_reg.act;
        st4_next.err   = st3_reg.err;
        st4_next.total = st3_reg.total;
        st4_next.doe   = st3_reg.doe;
        st4_next.yoe   = yoe_prod_s4[Q365_SH +: 9];
        st4_next.era   = st3_reg.era;
    end

    // ------------------------------------------------------------------
    // Stage 5: day of the March-based year and the March-based year number.
    // ------------------------------------------------------------------
    always_comb begin
        c100_prod_s5 = st4_reg.yoe * YOE100_MUL;
        yday_sum_s5  = 18'(st4_reg.yoe) * 18'(YEAR_DAYS) + 18'(st4_reg.yoe[8:2])
                       - 18'(c100_prod_s5[YOE100_SH +: 3]);

        st5_next.act   = st4_reg.act;
        st5_next.err   = st4_reg.err;
        st5_next.total = st4_reg.total;
        st5_next.doy   = 9'(st4_reg.doe - yday_sum_s5);
        st5_next.yr    = ERA_BASE_YEAR + 14'(st4_reg.era) * 14'(ERA_YEARS)
                         + 14'(st4_reg.yoe);
    end

    // ------------------------------------------------------------------
    // Stage 6: month of the March-based year, last offset not above the day.
    // ------------------------------------------------------------------
    always_comb begin
        st6_next.act   = st5_reg.act;
        st6_next.err   = st5_reg.err;
        st6_next.total = st5_reg.total;
        st6_next.doy   = st5_reg.doy;
        st6_next.yr    = st5_reg.yr;
        st6_next.mp    = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (st5_reg.doy >= march_offset(4'(k))) begin
                st6_next.mp = 4'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7 (result register): pass counts through; map dates back to January-based
    // months, bump the year for January and February, zero every field on error.
    // ------------------------------------------------------------------
    always_comb begin
        out_next = '0;
        if (st6_reg.err) begin
            out_next.error = 1'b1;
        end else if (st6_reg.act == ACT_TO_COUNT) begin
            out_next.count_out = st6_reg.total;
        end else begin
            out_next.year_out  = st6_reg.yr + 14'(st6_reg.mp >= MP_JAN);
            out_next.month_out = (st6_reg.mp < MP_JAN) ? (st6_reg.mp + 4'd3)
                                                       : (st6_reg.mp - 4'd9);
            out_next.day_out   = 5'(st6_reg.doy - march_offset(st6_reg.mp) + 9'd1);
        end
    end

    // Valid bits: cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload: load on advance, hold while stalled
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            st1_reg <= st1_next;
        end
        if (adv[2]) begin
            st2_reg <= st2_next;
        end
        if (adv[3]) begin
            st3_reg <= st3_next;
        end
        if (adv[4]) begin
            st4_reg <= st4_next;
        end
        if (adv[5]) begin
            st5_reg <= st5_next;
        end
        if (adv[6]) begin
            st6_reg <= st6_next;
        end
        if (adv[7]) begin
            out_reg <= out_next;
        end
    end

    assign s_ready = adv[1];
    assign m_valid = vld_reg[NUM_STAGES];
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### hdl/ddc_checker.sv
// Port-level checker for date_day_count_converter, bound to every instance.
// Depends on ddc_pkg for the transfer structs.
`default_nettype none

module ddc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input ddc_pkg::ddc_in_t   s_data,
    input logic               m_valid,
    input logic               m_ready,
    input ddc_pkg::ddc_out_t  m_data
);
    import ddc_pkg::*;

    // A stalled result holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Error results carry zero fields
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |->
            m_data.count_out == 22'd0 && m_data.year_out == 14'd0
            && m_data.month_out == 4'd0 && m_data.day_out == 5'd0)
        else $error("error result with nonzero fields");

    // A date result lies within the date ranges and carries no count
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.error && m_data.year_out != 14'd0 |->
            m_data.count_out == 22'd0
            && m_data.year_out >= BASE_YEAR && m_data.year_out <= LAST_YEAR
            && m_data.month_out >= 4'd1 && m_data.month_out <= MONTH_DEC
            && m_data.day_out >= 5'd1 && m_data.day_out <= 5'd31)
        else $error("date result out of range");

    // A count result carries no date and stays within 9999-12-31
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.year_out == 14'd0 |->
            m_data.month_out == 4'd0 && m_data.day_out == 5'd0
            && m_data.count_out <= MAX_COUNT)
        else $error("count result out of range");

endmodule

bind date_day_count_converter ddc_checker u_ddc_checker (.*);

`default_nettype wire
